[rtl/core/pid_itae_fitness_eval_defines.svh]
// Assertion macros used by the checker of the PID fitness evaluator.
`ifndef PID_ITAE_FITNESS_EVAL_DEFINES_SVH
`define PID_ITAE_FITNESS_EVAL_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define PITAE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define PITAE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/pitae_pkg.sv]
// Shared types and constants of the PID fitness evaluator.
package pitae_pkg;

    // Field widths of the channels and of the configuration port.
    localparam int PROP_W     = 23;
    localparam int INTEG_W    = 22;
    localparam int DERIV_W    = 21;
    localparam int LEVEL_W    = 24;
    localparam int FIT_W      = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int COST_W     = 40;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MAX    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic signed [LEVEL_W-1:0] TARGET_RESET    = 24'sh010000;
    localparam logic signed [LEVEL_W-1:0] DRIVE_MIN_RESET = 24'sh800000;
    localparam logic signed [LEVEL_W-1:0] DRIVE_MAX_RESET = 24'sh7FFFFF;

    // Plant and controller coefficients.
    localparam int WN_SQ       = 100;
    localparam int DAMP_COEF   = 10;
    localparam int DERIV_SCALE = 100;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ctrl_state_t;

    // Phases of one simulation step.
    typedef enum logic [2:0] {
        PH_ERR,
        PH_MUL1,
        PH_MUL2,
        PH_DRIVE,
        PH_ACC,
        PH_VPART,
        PH_VEL,
        PH_POS
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic   load;
        logic   run;
        phase_t phase;
        logic   publish;
    } dp_cmd_t;

endpackage

[rtl/core/pitae_gain_if.sv]
// Request channel carrying one candidate gain triple.
interface pitae_gain_if;
    import pitae_pkg::*;

    logic               valid;
    logic               ready;
    logic [PROP_W-1:0]  prop_gain;
    logic [INTEG_W-1:0] integ_gain;
    logic [DERIV_W-1:0] deriv_gain;

    modport source (output valid, output prop_gain, output integ_gain, output deriv_gain,
                    input ready);
    modport sink (input valid, input prop_gain, input integ_gain, input deriv_gain,
                  output ready);
endinterface

[rtl/core/pitae_fit_if.sv]
// Result channel carrying one fitness value.
interface pitae_fit_if;
    import pitae_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [FIT_W-1:0] fitness;

    modport source (output valid, output fitness, input ready);
    modport sink (input valid, input fitness, output ready);
endinterface

[rtl/core/pid_itae_fitness_eval.sv]
// Top level of the PID gain fitness evaluator.
//
//   channel   dir   handshake      payload
//   gains     in    valid/ready    prop_gain, integ_gain, deriv_gain
//   results   out   valid/ready    fitness
//   cfg       in    cfg_write      cfg_index, cfg_data
//
// An accepted request gives its result once all SIM_STEPS simulation steps have
// run: each simulation step runs through eight phases of the controller's
// step sequencer. The next request is taken in the cycle after the result is
// loaded into the output register, so a new run overlaps a result that waits.
// A finished run holds in its done state while the output register is still full.
// Reset returns the configuration registers to their reset values at once.
module pid_itae_fitness_eval #(
    parameter int SIM_STEPS = 200,
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    pitae_gain_if.sink                       gains,
    pitae_fit_if.source                      results,
    input  logic                             cfg_write,
    input  logic [pitae_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pitae_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pitae_pkg::*;

    dp_cmd_t cmd;

    // Sequencer.
    pitae_ctrl #(
        .SIM_STEPS (SIM_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gains.valid),
        .in_ready  (gains.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    // Arithmetic.
    pitae_datapath #(
        .SIM_STEPS (SIM_STEPS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .prop_gain  (gains.prop_gain),
        .integ_gain (gains.integ_gain),
        .deriv_gain (gains.deriv_gain),
        .fitness    (results.fitness)
    );

endmodule

[rtl/core/pitae_ctrl.sv]
// Controller: request handshake, step and phase sequencing, result valid.
module pitae_ctrl #(
    parameter int SIM_STEPS = 200
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output pitae_pkg::dp_cmd_t cmd
);
    import pitae_pkg::*;

    localparam int STEP_W = (SIM_STEPS > 1) ? $clog2(SIM_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SIM_STEPS - 1);

    ctrl_state_t       state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              last_phase;
    logic              out_free;

    // Phase order within one step.
    function automatic phase_t phase_after(input phase_t p);
        phase_t n;
        unique case (p)
            PH_ERR:   n = PH_MUL1;
            PH_MUL1:  n = PH_MUL2;
            PH_MUL2:  n = PH_DRIVE;
            PH_DRIVE: n = PH_ACC;
            PH_ACC:   n = PH_VPART;
            PH_VPART: n = PH_VEL;
            PH_VEL:   n = PH_POS;
            PH_POS:   n = PH_ERR;
            default:  n = PH_ERR;
        endcase
        return n;
    endfunction

    assign last_phase = (phase_reg == PH_POS) && (step_reg == LAST_STEP);
    assign out_free   = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_phase)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands.
    always_comb
    begin
        in_ready    = (state_reg == ST_IDLE);
        cmd.load    = (state_reg == ST_IDLE) && in_valid;
        cmd.run     = (state_reg == ST_RUN);
        cmd.phase   = phase_reg;
        cmd.publish = (state_reg == ST_DONE) && out_free;
        out_valid   = out_valid_reg;
    end

    // Step and phase counters, result valid flag.
    always_comb
    begin
        phase_next = phase_reg;
        step_next  = step_reg;
        if (cmd.load)
        begin
            phase_next = PH_ERR;
            step_next  = '0;
        end
        else if (cmd.run)
        begin
            phase_next = phase_after(phase_reg);
            if (phase_reg == PH_POS)
            begin
                step_next = step_reg + STEP_W'(1);
            end
        end

        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_ERR;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/core/pitae_datapath.sv]
// Datapath: configuration registers, PID loop, plant model and cost accumulator.
module pitae_datapath #(
    parameter int SIM_STEPS = 200,
    parameter int FRAC_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  pitae_pkg::dp_cmd_t                       cmd,
    input  logic                                     cfg_write,
    input  logic [pitae_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [pitae_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic [pitae_pkg::PROP_W-1:0]             prop_gain,
    input  logic [pitae_pkg::INTEG_W-1:0]            integ_gain,
    input  logic [pitae_pkg::DERIV_W-1:0]            deriv_gain,
    output logic signed [pitae_pkg::FIT_W-1:0]       fitness
);
    import pitae_pkg::*;

    // Time step, rounded half up, and derived widths.
    localparam int DT       = ((1 << FRAC_BITS) + 50) / 100;
    localparam int DT_W     = $clog2(DT + 1);
    localparam int T_W      = $clog2(SIM_STEPS * DT + 1);
    localparam int TM_W     = T_W + 32;
    localparam int TERM1_W  = 46;
    localparam int HALF_W   = TERM1_W / 2;
    localparam int TERM_W   = TERM1_W + DT_W;
    localparam int ACC_W    = 41;
    localparam int ACC_LO_W = 20;
    localparam int ACC_HI_W = ACC_W - ACC_LO_W;
    localparam int ACCDT_W  = ACC_W + DT_W + 1;
    localparam int USUM_W   = 58;

    localparam logic signed [DT_W:0]   DT_S = (DT_W + 1)'(DT);
    localparam logic        [DT_W-1:0] DT_U = DT_W'(DT);
    localparam logic [COST_W-1:0] COST_LIMIT = 40'h80_0000_0000;
    localparam logic [63:0]       TERM1_MAX  = 64'h0000_3FFF_FFFF_FFFF;

    // Saturation of a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > 64'sh0000_0000_7FFF_FFFF)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (x < 64'shFFFF_FFFF_8000_0000)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic signed [LEVEL_W-1:0] target_reg, dmin_reg, dmax_reg;

    // Per-item state and pipeline registers.
    logic [PROP_W-1:0]           kp_reg;
    logic [INTEG_W-1:0]          ki_reg;
    logic [DERIV_W-1:0]          kd_reg;
    logic signed [31:0]          y_reg, v_reg, integ_reg, e_reg, eprev_reg, de_reg;
    logic [T_W-1:0]              t_reg;
    logic [COST_W-1:0]           cost_reg;
    logic signed [55:0]          pe_reg;
    logic signed [54:0]          pi_reg;
    logic signed [53:0]          pd_reg;
    logic [TM_W-1:0]             tm_reg;
    logic [HALF_W+DT_W-1:0]      cl_reg, ch_reg;
    logic signed [LEVEL_W-1:0]   u_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_LO_W+DT_W+1:0] al_reg;
    logic signed [ACC_HI_W+DT_W:0]   ah_reg;
    logic signed [FIT_W-1:0]     fitness_reg;

    // Next values and intermediates.
    logic signed [31:0]          e_next, integ_next, de_next, v_next, y_next;
    logic signed [32+DT_W:0]     ie_prod, vy_prod;
    logic signed [32:0]          e_diff;
    logic signed [39:0]          de_full;
    logic signed [55:0]          pe_next;
    logic signed [54:0]          pi_next;
    logic signed [53:0]          pd_next;
    logic [31:0]                 mag;
    logic [TM_W-1:0]             tm_next, tm_sh;
    logic [TERM1_W-1:0]          term1;
    logic [HALF_W+DT_W-1:0]      cl_next, ch_next;
    logic [TERM_W-1:0]           term_full, term;
    logic                        term_big;
    logic [COST_W:0]             cost_sum;
    logic [COST_W-1:0]           cost_next;
    logic signed [USUM_W-1:0]    u_sum, u_clip;
    logic signed [LEVEL_W-1:0]   u_next;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [ACC_LO_W+DT_W+1:0] al_next;
    logic signed [ACC_HI_W+DT_W:0]   ah_next;
    logic signed [ACCDT_W-1:0]   av;
    logic [T_W-1:0]              t_next;
    logic signed [FIT_W-1:0]     fitness_next;

    // Error, integral and derivative.
    always_comb
    begin
        e_next     = sat32(64'(target_reg) - 64'(y_reg));
        ie_prod    = e_reg * DT_S;
        integ_next = sat32(64'(integ_reg) + 64'(ie_prod >>> FRAC_BITS));
        e_diff     = 33'(e_reg) - 33'(eprev_reg);
        de_full    = 40'(e_diff) * 40'(DERIV_SCALE);
        de_next    = sat32(64'(de_full));
    end

    // Gain products.
    always_comb
    begin
        pe_next = $signed({1'b0, kp_reg}) * e_reg;
        pi_next = $signed({1'b0, ki_reg}) * integ_reg;
        pd_next = $signed({1'b0, kd_reg}) * de_reg;
    end

    // Cost term: t*|e| first, then the time step in two partial products.
    always_comb
    begin
        mag     = e_reg[31] ? (~e_reg[31:0] + 32'd1) : e_reg[31:0];
        tm_next = TM_W'(t_reg) * TM_W'(mag);
        tm_sh   = tm_reg >> FRAC_BITS;
        if (64'(tm_sh) > TERM1_MAX)
        begin
            term1 = '1;
        end
        else
        begin
            term1 = TERM1_W'(tm_sh);
        end
        cl_next   = (HALF_W + DT_W)'(term1[HALF_W-1:0]) * (HALF_W + DT_W)'(DT_U);
        ch_next   = (HALF_W + DT_W)'(term1[TERM1_W-1:HALF_W]) * (HALF_W + DT_W)'(DT_U);
        term_full = {ch_reg, {HALF_W{1'b0}}} + TERM_W'(cl_reg);
        term      = term_full >> FRAC_BITS;
        term_big  = (term >= TERM_W'(COST_LIMIT));
        cost_sum  = {1'b0, cost_reg} + {1'b0, term[COST_W-1:0]};
        if (term_big || (cost_sum > (COST_W + 1)'(COST_LIMIT)))
        begin
            cost_next = COST_LIMIT;
        end
        else
        begin
            cost_next = cost_sum[COST_W-1:0];
        end
        fitness_next = $signed(40'd0 - cost_reg);
    end

    // Controller output with the upper limit applied before the lower.
    always_comb
    begin
        u_sum  = USUM_W'(pe_reg >>> FRAC_BITS) + USUM_W'(pi_reg >>> FRAC_BITS)
               + USUM_W'(pd_reg >>> FRAC_BITS);
        u_clip = u_sum;
        if (u_clip > USUM_W'(dmax_reg))
        begin
            u_clip = USUM_W'(dmax_reg);
        end
        if (u_clip < USUM_W'(dmin_reg))
        begin
            u_clip = USUM_W'(dmin_reg);
        end
        u_next = u_clip[LEVEL_W-1:0];
    end

    // Plant: acceleration, velocity and position by semi-implicit Euler (position uses the new velocity).
    always_comb
    begin
        acc_next = ACC_W'(WN_SQ) * (ACC_W'(u_reg) - ACC_W'(y_reg))
                 - ACC_W'(DAMP_COEF) * ACC_W'(v_reg);
        al_next  = $signed({1'b0, acc_reg[ACC_LO_W-1:0]}) * DT_S;
        ah_next  = $signed(acc_reg[ACC_W-1:ACC_LO_W]) * DT_S;
        av       = (ACCDT_W'(ah_reg) <<< ACC_LO_W) + ACCDT_W'(al_reg);
        v_next   = sat32(64'(v_reg) + 64'(av >>> FRAC_BITS));
        vy_prod  = v_reg * DT_S;
        y_next   = sat32(64'(y_reg) + 64'(vy_prod >>> FRAC_BITS));
        t_next   = t_reg + T_W'(DT);
    end

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
            dmin_reg   <= DRIVE_MIN_RESET;
            dmax_reg   <= DRIVE_MAX_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_TARGET_LEVEL: target_reg <= $signed(cfg_data);
                CFG_DRIVE_MIN:    dmin_reg   <= $signed(cfg_data);
                CFG_DRIVE_MAX:    dmax_reg   <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // Step registers, updated phase by phase.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kp_reg    <= prop_gain;
            ki_reg    <= integ_gain;
            kd_reg    <= deriv_gain;
            y_reg     <= '0;
            v_reg     <= '0;
            integ_reg <= '0;
            eprev_reg <= '0;
            t_reg     <= '0;
            cost_reg  <= '0;
        end
        else if (cmd.run)
        begin
            unique case (cmd.phase)
                PH_ERR:
                begin
                    e_reg <= e_next;
                end
                PH_MUL1:
                begin
                    integ_reg <= integ_next;
                    de_reg    <= de_next;
                    eprev_reg <= e_reg;
                    pe_reg    <= pe_next;
                    tm_reg    <= tm_next;
                end
                PH_MUL2:
                begin
                    pi_reg <= pi_next;
                    pd_reg <= pd_next;
                    cl_reg <= cl_next;
                    ch_reg <= ch_next;
                end
                PH_DRIVE:
                begin
                    u_reg    <= u_next;
                    cost_reg <= cost_next;
                end
                PH_ACC:
                begin
                    acc_reg <= acc_next;
                end
                PH_VPART:
                begin
                    al_reg <= al_next;
                    ah_reg <= ah_next;
                end
                PH_VEL:
                begin
                    v_reg <= v_next;
                end
                PH_POS:
                begin
                    y_reg <= y_next;
                    t_reg <= t_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Output register of the result channel.
    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            fitness_reg <= fitness_next;
        end
    end

    assign fitness = fitness_reg;

endmodule

[rtl/core/pitae_checker.sv]
// Port-level checker of the PID fitness evaluator and its bind.
`include "pid_itae_fitness_eval_defines.svh"

module pitae_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [pitae_pkg::FIT_W-1:0] fitness
);
    // A stalled result keeps its value.
    `PITAE_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(fitness), "result changed while stalled")

    // An accepted request makes the block busy.
    `PITAE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready stayed high after a request")

    // No result appears in the cycle after a request is taken.
    `PITAE_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result raised straight after a request")

    // Ready only drops on an accepted request.
    `PITAE_ASSERT_IMPL(a_ready_falls_on_accept, $fell(in_ready), $past(in_valid), "ready fell without a request")

endmodule

bind pid_itae_fitness_eval pitae_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (gains.valid),
    .in_ready  (gains.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .fitness   (results.fitness)
);
